// ===== rtl/gdnc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdnc_pkg
// Types, constants and small arithmetic helpers for the Gregorian day number
// converter (March-based serial day numbers, day 0 is 0000-03-01).
// ----------------------------------------------------------------------------
package gdnc_pkg;

	localparam int MODE_W  = 3;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DNUM_W  = 22;
	localparam int NUM_W   = 25;	// signed working width of day numbers

	localparam logic [MODE_W-1:0] MODE_TO_NUM   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FROM_NUM = 3'd1;
	localparam logic [MODE_W-1:0] MODE_NEXT     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PREV     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_BACK     = 3'd4;

	localparam logic [DNUM_W-1:0] DAY_NUMBER_MAX  = 22'd3652364;
	localparam logic [DNUM_W-1:0] DAYS_10K_YEARS  = 22'd3652425;
	localparam logic [13:0]       EST_SCALE       = 14'd10000;
	localparam logic [13:0]       EST_BIAS        = 14'd14780;
	localparam logic [23:0]       RECIP_YEAR      = 24'd11759221;	// 2^32 / 365.2425
	localparam logic [12:0]       RECIP25         = 13'd5243;		// 2^17 / 25
	localparam logic [14:0]       YEAR_BIAS       = 15'd400;
	localparam logic signed [NUM_W-1:0] DAYS_400_YEARS = 25'sd146097;
	localparam int                MI_LAST         = 16;

	// result side data that rides along after the day number is final
	typedef struct packed {
		logic [DNUM_W-1:0]  dnum;
		logic               flag;
		logic               uf;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} tail_t;

	// month index counted from March, 0..11
	function automatic logic [3:0] march_month(input logic [3:0] month);
		logic [3:0] m;
		priority if (month < 4'd3) begin
			m = month + 4'd9;
		end else if (month < 4'd15) begin
			m = month - 4'd3;
		end else begin
			m = 4'd0;
		end
		return m;
	endfunction

	// (306 * k + 5) / 10
	function automatic logic [8:0] month_start(input logic [4:0] k);
		logic [8:0] s;
		unique case (k)
			5'd0:    s = 9'd0;
			5'd1:    s = 9'd31;
			5'd2:    s = 9'd61;
			5'd3:    s = 9'd92;
			5'd4:    s = 9'd122;
			5'd5:    s = 9'd153;
			5'd6:    s = 9'd184;
			5'd7:    s = 9'd214;
			5'd8:    s = 9'd245;
			5'd9:    s = 9'd275;
			5'd10:   s = 9'd306;
			5'd11:   s = 9'd337;
			5'd12:   s = 9'd367;
			5'd13:   s = 9'd398;
			5'd14:   s = 9'd428;
			5'd15:   s = 9'd459;
			5'd16:   s = 9'd490;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// exact floor(x / 25) for x below 4200
	function automatic logic [7:0] div25(input logic [12:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'(RECIP25);
		return p[24:17];
	endfunction

	// day number of March 1 of year (yb - 400), yb >= 399
	function automatic logic signed [NUM_W-1:0] year_start(input logic [14:0] yb,
		input logic [7:0] q100, input logic [7:0] q400);
		logic [23:0] t;
		t = 24'(yb) * 24'd365 + 24'(yb[14:2]) - 24'(q100) + 24'(q400);
		return $signed({1'b0, t}) - DAYS_400_YEARS;
	endfunction

endpackage

// ===== rtl/gregorian_day_number_converter_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_number_converter_unit
// Date <-> March-based day number conversion, next/previous day and
// subtraction of a day count, with clamping to 0000-03-01 .. 9999-12-31.
// ----------------------------------------------------------------------------
// channel  handshake            payload
// request  in_valid / in_ready  mode, in_year, in_month, in_day,
//                               in_day_number, days_back
// result   out_valid/out_ready  out_year, out_month, out_day,
//                               out_day_number, range_flag
//
// Eleven register stages, s1 .. s11; a request passes through each in turn
// and its result is held on the result port from s11. One request per cycle
// is taken unless the result side stalls the pipe.
// The whole pipe advances together; out_ready low with a result waiting
// holds every stage and drops in_ready.
// arst_n clears only the stage valid bits.
// ----------------------------------------------------------------------------
module gregorian_day_number_converter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gdnc_pkg::MODE_W-1:0]  mode,
	input  logic [gdnc_pkg::YEAR_W-1:0]  in_year,
	input  logic [gdnc_pkg::MONTH_W-1:0] in_month,
	input  logic [gdnc_pkg::DAY_W-1:0]   in_day,
	input  logic [gdnc_pkg::DNUM_W-1:0]  in_day_number,
	input  logic [gdnc_pkg::DNUM_W-1:0]  days_back,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gdnc_pkg::YEAR_W-1:0]  out_year,
	output logic [gdnc_pkg::MONTH_W-1:0] out_month,
	output logic [gdnc_pkg::DAY_W-1:0]   out_day,
	output logic [gdnc_pkg::DNUM_W-1:0]  out_day_number,
	output logic                         range_flag
);
	import gdnc_pkg::*;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;

	assign adv      = ~vld_s11 | out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// ---- s1: March month, biased year, century quotients
	logic [3:0]  m_c;
	logic [14:0] yb_c;
	logic signed [9:0] dm_c;

	logic [MODE_W-1:0]  mode_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [DNUM_W-1:0]  dnum_s1, back_s1;
	logic [14:0]        yb_s1;
	logic [7:0]         q100_s1, q400_s1;
	logic signed [9:0]  dm_s1;

	always_comb begin
		m_c  = march_month(in_month);
		yb_c = 15'(in_year) + YEAR_BIAS - 15'(m_c >= 4'd10);
		dm_c = $signed({1'b0, month_start({1'b0, m_c})}) + $signed({5'b0, in_day}) - 10'sd1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1  <= mode;
			year_s1  <= in_year;
			month_s1 <= in_month;
			day_s1   <= in_day;
			dnum_s1  <= in_day_number;
			back_s1  <= days_back;
			yb_s1    <= yb_c;
			q100_s1  <= div25(yb_c[14:2]);
			q400_s1  <= div25(13'(yb_c[14:4]));
			dm_s1    <= dm_c;
		end
	end

	// ---- s2: day number of the input date
	logic [MODE_W-1:0]  mode_s2;
	logic [YEAR_W-1:0]  year_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [DNUM_W-1:0]  dnum_s2, back_s2;
	logic signed [NUM_W-1:0] ndate_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2  <= mode_s1;
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			dnum_s2  <= dnum_s1;
			back_s2  <= back_s1;
			ndate_s2 <= year_start(yb_s1, q100_s1, q400_s1)
				+ $signed({{(NUM_W-10){dm_s1[9]}}, dm_s1});
		end
	end

	// ---- s3: mode, underflow, clamp
	logic signed [NUM_W-1:0] t_c, nsel_c, ncl_c;
	logic uf_c;
	tail_t tail_c, tail_s3;

	always_comb begin
		t_c  = ndate_s2 - $signed({3'b0, back_s2});
		uf_c = (mode_s2 == MODE_BACK) && t_c[NUM_W-1];
		priority if (mode_s2 == MODE_FROM_NUM) begin
			nsel_c = $signed({3'b0, dnum_s2});
		end else if (mode_s2 == MODE_NEXT) begin
			nsel_c = ndate_s2 + 25'sd1;
		end else if (mode_s2 == MODE_PREV) begin
			nsel_c = ndate_s2 - 25'sd1;
		end else if (mode_s2 == MODE_BACK) begin
			nsel_c = t_c;
		end else begin
			nsel_c = ndate_s2;
		end
		ncl_c = uf_c ? ndate_s2 : nsel_c;

		tail_c.uf    = uf_c;
		tail_c.year  = year_s2;
		tail_c.month = month_s2;
		tail_c.day   = day_s2;
		priority if (ncl_c[NUM_W-1]) begin
			tail_c.dnum = '0;
			tail_c.flag = 1'b1;
		end else if (ncl_c > $signed({3'b0, DAY_NUMBER_MAX})) begin
			tail_c.dnum = DAY_NUMBER_MAX;
			tail_c.flag = 1'b1;
		end else begin
			tail_c.dnum = ncl_c[DNUM_W-1:0];
			tail_c.flag = uf_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s3 <= tail_c;
		end
	end

	// ---- s4: year estimate by reciprocal, may be one low
	logic [45:0] est_c;
	logic [13:0] q0_s4;
	tail_t tail_s4;

	assign est_c = 46'(tail_s3.dnum) * 46'(RECIP_YEAR);

	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s4   <= est_c[45:32];
			tail_s4 <= tail_s3;
		end
	end

	// ---- s5: (q0 + 1) * 3652425 against 10000 n + 14780
	logic [13:0] q0_s5;
	logic [35:0] prodp_s5, x_s5;
	tail_t tail_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s5    <= q0_s4;
			prodp_s5 <= (36'(q0_s4) + 36'd1) * 36'(DAYS_10K_YEARS);
			x_s5     <= 36'(tail_s4.dnum) * 36'(EST_SCALE) + 36'(EST_BIAS);
			tail_s5  <= tail_s4;
		end
	end

	// ---- s6: exact quotient
	logic [YEAR_W-1:0] y_s6;
	tail_t tail_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s6    <= q0_s5 + 14'(x_s5 >= prodp_s5);
			tail_s6 <= tail_s5;
		end
	end

	// ---- s7: century quotients for year y and y - 1
	logic [14:0] ya_c, yb1_c;
	logic [14:0] ya_s7, yb_s7;
	logic [7:0]  qa100_s7, qa400_s7, qb100_s7, qb400_s7;
	logic [YEAR_W-1:0] y_s7;
	tail_t tail_s7;

	assign ya_c  = 15'(y_s6) + YEAR_BIAS;
	assign yb1_c = ya_c - 15'd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ya_s7    <= ya_c;
			yb_s7    <= yb1_c;
			qa100_s7 <= div25(ya_c[14:2]);
			qa400_s7 <= div25(13'(ya_c[14:4]));
			qb100_s7 <= div25(yb1_c[14:2]);
			qb400_s7 <= div25(13'(yb1_c[14:4]));
			y_s7     <= y_s6;
			tail_s7  <= tail_s6;
		end
	end

	// ---- s8: year start days
	logic signed [NUM_W-1:0] ysa_s8, ysb_s8;
	logic [YEAR_W-1:0] y_s8;
	tail_t tail_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			ysa_s8  <= year_start(ya_s7, qa100_s7, qa400_s7);
			ysb_s8  <= year_start(yb_s7, qb100_s7, qb400_s7);
			y_s8    <= y_s7;
			tail_s8 <= tail_s7;
		end
	end

	// ---- s9: day within the March year
	logic signed [NUM_W-1:0] da_c, db_c;
	logic [8:0] ddd_s9;
	logic [YEAR_W-1:0] yr_s9;
	tail_t tail_s9;

	assign da_c = $signed({3'b0, tail_s8.dnum}) - ysa_s8;
	assign db_c = $signed({3'b0, tail_s8.dnum}) - ysb_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			ddd_s9  <= da_c[NUM_W-1] ? db_c[8:0] : da_c[8:0];
			yr_s9   <= da_c[NUM_W-1] ? y_s8 - 14'd1 : y_s8;
			tail_s9 <= tail_s8;
		end
	end

	// ---- s10: month index from March
	logic [4:0] mi_c, mi_s10;
	logic [8:0] ddd_s10;
	logic [YEAR_W-1:0] yr_s10;
	tail_t tail_s10;

	always_comb begin
		mi_c = '0;
		for (int k = 1; k <= MI_LAST; k++) begin
			mi_c = mi_c + 5'(ddd_s9 >= month_start(5'(k)));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mi_s10   <= mi_c;
			ddd_s10  <= ddd_s9;
			yr_s10   <= yr_s9;
			tail_s10 <= tail_s9;
		end
	end

	// ---- s11: calendar fields, output register
	logic [4:0] mi2_c;
	logic       wrap_c;
	logic [8:0] dd_c;
	logic [YEAR_W-1:0]  year_s11;
	logic [MONTH_W-1:0] month_s11;
	logic [DAY_W-1:0]   day_s11;
	logic [DNUM_W-1:0]  dnum_s11;
	logic               flag_s11;

	always_comb begin
		mi2_c  = mi_s10 + 5'd2;
		wrap_c = mi2_c >= 5'd12;
		dd_c   = ddd_s10 - month_start(mi_s10) + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dnum_s11 <= tail_s10.dnum;
			flag_s11 <= tail_s10.flag;
			if (tail_s10.uf) begin
				year_s11  <= tail_s10.year;
				month_s11 <= tail_s10.month;
				day_s11   <= tail_s10.day;
			end else begin
				year_s11  <= yr_s10 + 14'(wrap_c);
				month_s11 <= 4'(wrap_c ? mi2_c - 5'd12 : mi2_c) + 4'd1;
				day_s11   <= dd_c[4:0];
			end
		end
	end

	assign out_valid      = vld_s11;
	assign out_year       = year_s11;
	assign out_month      = month_s11;
	assign out_day        = day_s11;
	assign out_day_number = dnum_s11;
	assign range_flag     = flag_s11;

	// ---- checks
	a_dnum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_day_number <= DAY_NUMBER_MAX)
		else $error("day number beyond range");

	a_year_est: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> y_s6 <= 14'd10000)
		else $error("year estimate out of range");

	a_day_in_year: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 |-> ddd_s9 <= 9'd365)
		else $error("day within year out of range");

	a_date_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_flag |-> out_month >= 4'd1 && out_month <= 4'd12
			&& out_day != 5'd0)
		else $error("malformed date without range flag");

endmodule

// ===== verif/gregorian_day_number_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_day_number_converter_unit_tb
// Self-checking bench for the date / day number converter. A directed set
// covers range ends, clamping, rollover, underflow and every mode. Random
// requests with mostly well-formed dates and random stalls on both sides
// follow. Every result is checked against a behavioral model of the block.
// ----------------------------------------------------------------------------
module gregorian_day_number_converter_unit_tb;

	import gdnc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
	localparam longint LAST_DAY      = DAY_NUMBER_MAX;
	localparam longint DNUM_ALL_ONES = 22'h3FFFFF;
	localparam int     RANDOM_REQS   = 800;
	localparam int     STALL_LIMIT   = 2000;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [DNUM_W-1:0]  dnum;
		logic [DNUM_W-1:0]  back;
	} date_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [DNUM_W-1:0]  dnum;
		logic               flag;
	} date_res_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [MODE_W-1:0]   mode;
	logic [YEAR_W-1:0]   in_year;
	logic [MONTH_W-1:0]  in_month;
	logic [DAY_W-1:0]    in_day;
	logic [DNUM_W-1:0]   in_day_number;
	logic [DNUM_W-1:0]   days_back;
	logic                out_valid;
	logic                out_ready;
	logic [YEAR_W-1:0]   out_year;
	logic [MONTH_W-1:0]  out_month;
	logic [DAY_W-1:0]    out_day;
	logic [DNUM_W-1:0]   out_day_number;
	logic                range_flag;

	date_req_t   pending_reqs[$];
	date_res_t   expected_dates[$];
	date_req_t   cur_req;
	logic        req_taken;
	int          send_gap;
	int          stall_left;
	int          reqs_queued;
	int          reqs_accepted;
	int          mismatch_count;
	int          idle_cycles;
	int unsigned cycle_count;

	assign mode          = cur_req.mode;
	assign in_year       = cur_req.year;
	assign in_month      = cur_req.month;
	assign in_day        = cur_req.day;
	assign in_day_number = cur_req.dnum;
	assign days_back     = cur_req.back;

	gregorian_day_number_converter_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// day number of March 1 of March-year y, y >= -400
	function automatic longint march_year_start(input longint y);
		longint yb;
		yb = y + 400;
		return 365 * yb + yb / 4 - yb / 100 + yb / 400 - 146097;
	endfunction

	function automatic longint date_day_number(input logic [YEAR_W-1:0] yr,
		input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy);
		longint m, y, d;
		m = longint'(mo);
		y = longint'(yr);
		d = longint'(dy);
		m = (m + 9) % 12;
		y = y - m / 10;
		return march_year_start(y) + (m * 306 + 5) / 10 + d - 1;
	endfunction

	function automatic date_res_t convert_date(input date_req_t r);
		date_res_t res;
		longint    n, t, y, ddd, mi;
		bit        under;
		res = '0;
		under = 1'b0;
		if (r.mode == MODE_FROM_NUM) begin
			n = longint'(r.dnum);
		end else begin
			n = date_day_number(r.year, r.month, r.day);
			if (r.mode == MODE_NEXT) begin
				n = n + 1;
			end else if (r.mode == MODE_PREV) begin
				n = n - 1;
			end else if (r.mode == MODE_BACK) begin
				t = n;
				t = t - longint'(r.back);
				if (t < 0) begin
					under = 1'b1;
				end else begin
					n = t;
				end
			end
		end
		if (n < 0) begin
			n = 0;
			res.flag = 1'b1;
		end else if (n > LAST_DAY) begin
			n = LAST_DAY;
			res.flag = 1'b1;
		end
		res.dnum = DNUM_W'(n);
		if (under) begin
			res.year = r.year;
			res.month = r.month;
			res.day = r.day;
			res.flag = 1'b1;
		end else begin
			y = (10000 * n + 14780) / 3652425;
			ddd = n - march_year_start(y);
			if (ddd < 0) begin
				y = y - 1;
				ddd = n - march_year_start(y);
			end
			mi = (100 * ddd + 52) / 3060;
			res.month = MONTH_W'((mi + 2) % 12 + 1);
			res.year = YEAR_W'(y + (mi + 2) / 12);
			res.day = DAY_W'(ddd - (mi * 306 + 5) / 10 + 1);
		end
		return res;
	endfunction

	function automatic int month_length(input logic [YEAR_W-1:0] yr,
		input logic [MONTH_W-1:0] mo);
		int len;
		if (mo == 4'd2) begin
			len = ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 29 : 28;
		end else if (mo == 4'd4 || mo == 4'd6 || mo == 4'd9 || mo == 4'd11) begin
			len = 30;
		end else begin
			len = 31;
		end
		return len;
	endfunction

	// calm stretches get no idling at all
	function automatic int idle_len(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_req(input logic [MODE_W-1:0] md, input logic [YEAR_W-1:0] yr,
		input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
		input logic [DNUM_W-1:0] dn, input logic [DNUM_W-1:0] bk);
		pending_reqs.push_back({md, yr, mo, dy, dn, bk});
		reqs_queued++;
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !req_taken) begin
				// hold until accepted
			end else if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() != 0) begin
				cur_req <= pending_reqs.pop_front();
				in_valid <= 1'b1;
				send_gap <= idle_len(((cycle_count >> 8) % 4) == 0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left <= idle_len(((cycle_count >> 8) % 4) == 0);
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin : monitor
		date_res_t want;
		if (arst_n) begin
			cycle_count++;
			req_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					$error("unexpected result: year %0d month %0d day %0d number %0d",
						out_year, out_month, out_day, out_day_number);
					mismatch_count++;
				end else begin
					want = expected_dates.pop_front();
					if (out_year !== want.year) begin
						$error("out_year: expected %0d, got %0d", want.year, out_year);
						mismatch_count++;
					end
					if (out_month !== want.month) begin
						$error("out_month: expected %0d, got %0d", want.month, out_month);
						mismatch_count++;
					end
					if (out_day !== want.day) begin
						$error("out_day: expected %0d, got %0d", want.day, out_day);
						mismatch_count++;
					end
					if (out_day_number !== want.dnum) begin
						$error("out_day_number: expected %0d, got %0d", want.dnum,
							out_day_number);
						mismatch_count++;
					end
					if (range_flag !== want.flag) begin
						$error("range_flag: expected %0d, got %0d", want.flag, range_flag);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_dates.push_back(convert_date(cur_req));
				reqs_accepted++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		longint                base_num;
		longint                back_num;
		int                    pick;
		int                    len;
		logic [MODE_W-1:0]     r_mode;
		logic [YEAR_W-1:0]     r_year;
		logic [MONTH_W-1:0]    r_month;
		logic [DAY_W-1:0]      r_day;
		logic [DNUM_W-1:0]     r_dnum;
		logic [DNUM_W-1:0]     r_back;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cur_req = '0;
		req_taken = 1'b0;
		send_gap = 0;
		stall_left = 0;
		reqs_queued = 0;
		reqs_accepted = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		cycle_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		base_num = date_day_number(14'd2024, 4'd3, 5'd1);
		queue_req(MODE_TO_NUM, 14'd0, 4'd3, 5'd1, '0, '0);
		queue_req(MODE_TO_NUM, 14'd9999, 4'd12, 5'd31, '0, '0);
		queue_req(MODE_TO_NUM, 14'd0, 4'd1, 5'd1, '0, '0);
		queue_req(MODE_TO_NUM, 14'd0, 4'd2, 5'd29, '0, '0);
		queue_req(MODE_TO_NUM, 14'h3FFF, 4'hF, 5'h1F, 22'h3FFFFF, 22'h3FFFFF);
		queue_req(MODE_TO_NUM, 14'd2000, 4'd2, 5'd30, '0, '0);
		queue_req(MODE_TO_NUM, 14'd1, 4'd0, 5'd0, '0, '0);
		queue_req(MODE_FROM_NUM, 14'd0, 4'd1, 5'd1, 22'd0, '0);
		queue_req(MODE_FROM_NUM, 14'd0, 4'd1, 5'd1, DAY_NUMBER_MAX, '0);
		queue_req(MODE_FROM_NUM, 14'd0, 4'd1, 5'd1, DAY_NUMBER_MAX + 22'd1, '0);
		queue_req(MODE_FROM_NUM, 14'd0, 4'd1, 5'd1, 22'h3FFFFF, '0);
		queue_req(MODE_NEXT, 14'd9999, 4'd12, 5'd31, '0, '0);
		queue_req(MODE_NEXT, 14'd2000, 4'd2, 5'd28, '0, '0);
		queue_req(MODE_NEXT, 14'd1900, 4'd2, 5'd28, '0, '0);
		queue_req(MODE_PREV, 14'd0, 4'd3, 5'd1, '0, '0);
		queue_req(MODE_PREV, 14'd2000, 4'd3, 5'd1, '0, '0);
		queue_req(MODE_BACK, 14'd2024, 4'd3, 5'd1, '0, 22'd0);
		queue_req(MODE_BACK, 14'd2024, 4'd3, 5'd1, '0, DNUM_W'(base_num));
		queue_req(MODE_BACK, 14'd2024, 4'd3, 5'd1, '0, DNUM_W'(base_num + 1));
		queue_req(MODE_BACK, 14'd9999, 4'd12, 5'd31, '0, 22'h3FFFFF);
		queue_req(MODE_BACK, 14'h3FFF, 4'd12, 5'd31, '0, 22'd0);
		queue_req(MODE_BACK, 14'd0, 4'd1, 5'd1, '0, 22'd0);
		queue_req(MODE_SPARE_FIRST, 14'd2024, 4'd2, 5'd29, '0, 22'd5);
		queue_req(MODE_SPARE_FIRST + 3'd1, 14'd1999, 4'd12, 5'd31, '0, 22'd5);
		queue_req(MODE_SPARE_LAST, 14'd2100, 4'd2, 5'd29, '0, 22'd5);

		// let the pipe drain completely before the random part
		while (reqs_accepted != reqs_queued) @(negedge clk);
		while (expected_dates.size() != 0) @(negedge clk);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				r_mode = MODE_TO_NUM;
			end else if (pick < 40) begin
				r_mode = MODE_FROM_NUM;
			end else if (pick < 55) begin
				r_mode = MODE_NEXT;
			end else if (pick < 70) begin
				r_mode = MODE_PREV;
			end else if (pick < 90) begin
				r_mode = MODE_BACK;
			end else begin
				r_mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
			end

			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				r_year = YEAR_W'($urandom_range(0, 9999));
			end else if (pick < 85) begin
				r_year = YEAR_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
					: $urandom_range(9996, 9999));
			end else begin
				r_year = YEAR_W'($urandom_range(0, 16383));
			end

			if ($urandom_range(0, 9) != 0) begin
				r_month = MONTH_W'($urandom_range(1, 12));
				len = month_length(r_year, r_month);
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					r_day = DAY_W'($urandom_range(1, len));
				end else if (pick < 85) begin
					r_day = DAY_W'(len);
				end else begin
					r_day = DAY_W'($urandom_range(0, 31));
				end
			end else begin
				r_month = MONTH_W'($urandom_range(0, 15));
				r_day = DAY_W'($urandom_range(0, 31));
			end

			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				r_dnum = DNUM_W'($urandom_range(0, LAST_DAY));
			end else if (pick < 75) begin
				r_dnum = DNUM_W'($urandom_range(0, 1) ? $urandom_range(0, 400)
					: $urandom_range(LAST_DAY - 400, LAST_DAY));
			end else begin
				r_dnum = DNUM_W'($urandom_range(0, DNUM_ALL_ONES));
			end

			base_num = date_day_number(r_year, r_month, r_day);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r_back = DNUM_W'($urandom_range(0, 1000));
			end else if (pick < 70) begin
				r_back = DNUM_W'($urandom_range(0, LAST_DAY));
			end else if (pick < 90) begin
				// straddle the underflow boundary
				back_num = base_num + longint'($urandom_range(0, 4)) - 2;
				if (back_num < 0)
					back_num = 0;
				if (back_num > DNUM_ALL_ONES)
					back_num = DNUM_ALL_ONES;
				r_back = DNUM_W'(back_num);
			end else begin
				r_back = DNUM_W'($urandom_range(0, DNUM_ALL_ONES));
			end

			queue_req(r_mode, r_year, r_month, r_day, r_dnum, r_back);
		end

		while (reqs_accepted != reqs_queued) @(negedge clk);
		while (expected_dates.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);

		if (mismatch_count == 0 && expected_dates.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
